>>> hdl/rar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational arithmetic reducer
// Operation codes, output field widths, datapath command and status words.
// ----------------------------------------------------------------------------
package rar_pkg;

  // default operand width for the top level
  localparam int OPERAND_WIDTH_DEF = 16;

  // fixed output field widths
  localparam int NUM_OUT_W = 34;
  localparam int DEN_OUT_W = 33;
  localparam int MDATA_W   = ((NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;

  // operation codes
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] OP_ADD = 2'd0;
  localparam logic [REQ_W-1:0] OP_SUB = 2'd1;
  localparam logic [REQ_W-1:0] OP_MUL = 2'd2;
  localparam logic [REQ_W-1:0] OP_DIV = 2'd3;

  // multiplier operand selection
  localparam logic [1:0] MS_T1   = 2'd0;  // first numerator term
  localparam logic [1:0] MS_T2   = 2'd1;  // second numerator term
  localparam logic [1:0] MS_DEN  = 2'd2;  // denominator
  localparam logic [1:0] MS_NONE = 2'd3;

  // numerator accumulator action
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_COMB = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       in_load;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       den_load;
    logic       gcd_load;
    logic       gcd_step;
    logic       div_load;
    logic       div_step;
    logic       out_load;
  } rar_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trivial;   // zero numerator or zero denominator
    logic gcd_done;
  } rar_stat_t;

endpackage

>>> hdl/rar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_ctrl: sequencer for the rational arithmetic reducer
// Steps the shared multiplier, the GCD loop and the dividers, and owns
// the stream handshakes.
// ----------------------------------------------------------------------------
module rar_ctrl import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  rar_stat_t stat,
  output rar_cmd_t  cmd
);

  localparam int NW = 2 * OPERAND_WIDTH;
  localparam int CW = $clog2(NW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_M4   = 4'd4;
  localparam logic [3:0] S_PREP = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_GSH  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_valid, out_valid_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel = MS_NONE;
    cmd.acc_op  = ACC_HOLD;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.in_load = 1'b1;
          state_next  = S_M1;
        end
      end
      S_M1: begin
        cmd.mul_sel = MS_T1;
        state_next  = S_M2;
      end
      S_M2: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MS_T2;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.acc_op  = ACC_COMB;
        cmd.mul_sel = MS_DEN;
        state_next  = S_M4;
      end
      S_M4: begin
        cmd.den_load = 1'b1;
        state_next   = S_PREP;
      end
      S_PREP: begin
        if (stat.trivial) begin
          state_next = S_DONE;
        end else begin
          cmd.gcd_load = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          state_next = S_GSH;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GSH: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // the GCD loop is never stepped once one operand has reached zero
  assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_step |-> !stat.gcd_done)
    else $error("gcd stepped after completion");

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("pending output word overwritten");

  // division runs exactly NW steps before the result is loaded
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == CW'(NW - 1)) |=> state == S_DONE)
    else $error("division step count wrong");

endmodule

>>> hdl/rar_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_dpath: datapath for the rational arithmetic reducer
// Shared signed multiplier, numerator accumulator, binary GCD and two
// restoring divider lanes, plus the output register.
// ----------------------------------------------------------------------------
module rar_dpath import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rar_cmd_t                   cmd,
  output rar_stat_t                  stat,
  input  logic [REQ_W-1:0]           req_type,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic signed [NUM_OUT_W-1:0] res_num,
  output logic [DEN_OUT_W-1:0]       res_den,
  output logic                       zero_den_error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * W;                 // magnitude width
  localparam int AW = NW + 1;                // accumulator width
  localparam int KW = $clog2(NW);
  localparam int XW = (NW > NUM_OUT_W) ? NW : NUM_OUT_W;

  // captured input word
  logic [REQ_W-1:0]     op;
  logic signed [W-1:0]  an, ad, bn, bd;

  // multiplier
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [NW-1:0] mul_ax, mul_bx, prod;

  // accumulated numerator and denominator
  logic signed [AW-1:0] acc;
  logic signed [NW-1:0] den;
  logic [AW-1:0]        nabs, dabs;
  logic [NW-1:0]        nmag, dmag;
  logic                 neg;

  // gcd
  logic [NW-1:0]        gx, gy, g;
  logic [KW-1:0]        gk;

  // divider lanes
  logic [NW-1:0]        qn, qd;
  logic [NW:0]          rn, rd, rn_sh, rd_sh;
  logic                 ge_n, ge_d;

  // result
  logic [XW-1:0]        qx, nx;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op <= req_type;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
  end

  // multiplier operand selection by phase and operation
  always_comb begin
    mul_a = an;
    mul_b = bd;
    unique case (cmd.mul_sel)
      MS_T1: begin
        mul_a = an;
        mul_b = (op == OP_MUL) ? bn : bd;
      end
      MS_T2: begin
        mul_a = ad;
        mul_b = bn;
      end
      MS_DEN: begin
        mul_a = ad;
        mul_b = (op == OP_DIV) ? bn : bd;
      end
      MS_NONE: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  assign mul_ax = NW'(mul_a);
  assign mul_bx = NW'(mul_b);

  always_ff @(posedge clk) begin
    prod <= mul_ax * mul_bx;
  end

  // numerator accumulate, denominator capture
  always_ff @(posedge clk) begin
    if (cmd.acc_op == ACC_LOAD) begin
      acc <= AW'(prod);
    end else if (cmd.acc_op == ACC_COMB) begin
      unique case (op)
        OP_ADD: acc <= acc + AW'(prod);
        OP_SUB: acc <= acc - AW'(prod);
        OP_MUL: acc <= acc;
        OP_DIV: acc <= acc;
      endcase
    end
    if (cmd.den_load) begin
      den <= prod;
    end
  end

  // magnitudes and result sign
  always_comb begin
    nabs = acc[AW-1] ? (AW'(0) - acc) : acc;
    dabs = den[NW-1] ? (AW'(0) - AW'(den)) : AW'(den);
    nmag = nabs[NW-1:0];
    dmag = dabs[NW-1:0];
    neg  = acc[AW-1] ^ den[NW-1];
  end

  assign stat.trivial  = (nmag == '0) || (dmag == '0);
  assign stat.gcd_done = (gx == '0) || (gy == '0);

  // binary gcd, one step per cycle
  always_ff @(posedge clk) begin
    if (cmd.gcd_load) begin
      gx <= nmag;
      gy <= dmag;
      gk <= '0;
    end else if (cmd.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 1'b1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
    if (cmd.div_load) begin
      g <= (gx | gy) << gk;
    end
  end

  // restoring divider lanes, numerator and denominator side by side
  always_comb begin
    rn_sh = {rn[NW-1:0], qn[NW-1]};
    rd_sh = {rd[NW-1:0], qd[NW-1]};
    ge_n  = (rn_sh >= {1'b0, g});
    ge_d  = (rd_sh >= {1'b0, g});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      qn <= nmag;
      qd <= dmag;
      rn <= '0;
      rd <= '0;
    end else if (cmd.div_step) begin
      rn <= ge_n ? (rn_sh - {1'b0, g}) : rn_sh;
      rd <= ge_d ? (rd_sh - {1'b0, g}) : rd_sh;
      qn <= {qn[NW-2:0], ge_n};
      qd <= {qd[NW-2:0], ge_d};
    end
  end

  // signed reduced numerator
  always_comb begin
    qx = XW'(qn);
    nx = neg ? (XW'(0) - qx) : qx;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (dmag == '0) begin
        res_num        <= '0;
        res_den        <= '0;
        zero_den_error <= 1'b1;
      end else if (nmag == '0) begin
        res_num        <= '0;
        res_den        <= DEN_OUT_W'(1);
        zero_den_error <= 1'b0;
      end else begin
        res_num        <= nx[NUM_OUT_W-1:0];
        res_den        <= DEN_OUT_W'(XW'(qd));
        zero_den_error <= 1'b0;
      end
    end
  end

  // the divisor is never zero once loaded
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |=> g != '0)
    else $error("gcd is zero");

  // the gcd divides both magnitudes exactly
  assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !stat.trivial) |-> (rn == '0 && rd == '0))
    else $error("reduction left a remainder");

  // the gcd loop only starts on nonzero magnitudes
  assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_load |-> (nmag != '0 && dmag != '0))
    else $error("gcd started on a zero operand");

endmodule

>>> hdl/rational_arithmetic_reduce.sv
`timescale 1ns / 1ps
// Sequence: a zero numerator or zero denominator skips the binary GCD loop and the
//   dividers; otherwise the GCD loop runs until one operand reaches zero, and the
//   divider lanes then run on both magnitudes before the result is loaded.
// Flow: one item at a time; the next word is taken in the cycle after the
//   result is loaded, and a stalled output word holds the sequencer.
// Reset: synchronous, active high; clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce: exact add/sub/mul/div of two signed fractions
// Forms the cross products, then reduces to lowest terms with a positive
// denominator; flags a zero result denominator.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // input words
  input  logic s_tvalid,
  output logic s_tready,
  // a_num, a_den, b_num, b_den from bit 0 up, zero filled to bytes
  input  logic [((4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // req_type
  input  logic [REQ_W-1:0] s_tuser,
  // output words
  output logic m_tvalid,
  input  logic m_tready,
  // res_num, res_den from bit 0 up, zero filled to bytes
  output logic [MDATA_W-1:0] m_tdata,
  // zero_den_error
  output logic m_tuser
);

  localparam int W = OPERAND_WIDTH;

  rar_cmd_t  cmd;
  rar_stat_t stat;

  logic signed [NUM_OUT_W-1:0] res_num;
  logic [DEN_OUT_W-1:0]        res_den;
  logic                        zero_den_error;

  // sequencer
  rar_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic
  rar_dpath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (s_tuser),
    .a_num          (s_tdata[W-1:0]),
    .a_den          (s_tdata[2*W-1:W]),
    .b_num          (s_tdata[3*W-1:2*W]),
    .b_den          (s_tdata[4*W-1:3*W]),
    .res_num        (res_num),
    .res_den        (res_den),
    .zero_den_error (zero_den_error)
  );

  // pack output word
  assign m_tdata = MDATA_W'({res_den, res_num});
  assign m_tuser = zero_den_error;

endmodule
